>>> rtl/core/rotated_sprite_quad_setup_assert.svh
// ----------------------------------------------------------------------------
// Rotated sprite quad setup - assertion macros
// Shared property forms for the sprite quad setup checks.
// ----------------------------------------------------------------------------
`ifndef ROTATED_SPRITE_QUAD_SETUP_ASSERT_SVH
`define ROTATED_SPRITE_QUAD_SETUP_ASSERT_SVH

// same-cycle implication
`define RSQS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rsqs: same-cycle check failed");

// next-cycle implication
`define RSQS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rsqs: next-cycle check failed");

`endif

>>> rtl/core/rsqs_pkg.sv
// ----------------------------------------------------------------------------
// Rotated sprite quad setup - package
// Widths, register codes, CORDIC table and pipeline record types.
// ----------------------------------------------------------------------------
package rsqs_pkg;

  localparam int TEXEL_BITS   = 14;
  localparam int UV_FRAC_BITS = 16;

  localparam int POS_W      = 24;
  localparam int PIVOT_W    = 19;
  localparam int SCALE_W    = 16;
  localparam int ANGLE_W    = 16;
  localparam int FLIP_W     = 3;
  localparam int COLOR_W    = 32;
  localparam int SIZE_W     = 15;
  localparam int OPAC_W     = 9;
  localparam int UV_W       = UV_FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int CORDIC_STEPS = 16;
  localparam int XY_W         = 20;
  localparam int Z_W          = 24;

  localparam int OX_W      = ((TEXEL_BITS + 5) > PIVOT_W ? TEXEL_BITS + 5 : PIVOT_W) + 1;
  localparam int OFF_W     = OX_W + 1;
  localparam int PROD_W    = OFF_W + XY_W;
  localparam int ROT_W     = PROD_W + 1;
  localparam int SPROD_W   = ROT_W + SCALE_W + 1;
  localparam int RND_SHIFT = 20;
  localparam int DX_W      = SPROD_W - RND_SHIFT;
  localparam int SUM_W     = DX_W + 1;
  localparam int TEX_W     = TEXEL_BITS + 1;
  localparam int VX_DEPTH  = UV_FRAC_BITS + 1;

  localparam logic signed [XY_W-1:0] CORDIC_K = XY_W'(39797);

  localparam logic [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
    24'd166669,  24'd83416,   24'd41718,  24'd20860,
    24'd10430,   24'd5215,    24'd2608,   24'd1304,
    24'd652,     24'd326,     24'd163,    24'd81
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_W   = 2'd0,
    CFG_TEX_H   = 2'd1,
    CFG_OPACITY = 2'd2,
    CFG_API     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic [TEXEL_BITS-1:0]    sx;
    logic [TEXEL_BITS-1:0]    sy;
    logic [TEXEL_BITS-1:0]    sw;
    logic [TEXEL_BITS-1:0]    sh;
    logic                     fx;
    logic                     fy;
    logic signed [OX_W-1:0]   ox;
    logic signed [OX_W-1:0]   oy;
    logic [SCALE_W-1:0]       scl;
    logic [COLOR_W-1:0]       color;
    logic [1:0]               quad;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
  } spr_t;

  typedef struct packed {
    logic signed [POS_W-1:0]   px;
    logic signed [POS_W-1:0]   py;
    logic [SCALE_W-1:0]        scl;
    logic signed [OFF_W-1:0]   offx;
    logic signed [OFF_W-1:0]   offy;
    logic signed [XY_W-1:0]    c;
    logic signed [XY_W-1:0]    s;
    logic signed [PROD_W-1:0]  mx1;
    logic signed [PROD_W-1:0]  mx2;
    logic signed [PROD_W-1:0]  my1;
    logic signed [PROD_W-1:0]  my2;
    logic signed [ROT_W-1:0]   rx;
    logic signed [ROT_W-1:0]   ry;
    logic signed [SPROD_W-1:0] prx;
    logic signed [SPROD_W-1:0] pry;
    logic signed [POS_W-1:0]   vx;
    logic signed [POS_W-1:0]   vy;
    logic [SIZE_W-1:0]         ud;
    logic [SIZE_W-1:0]         vd;
    logic [SIZE_W-1:0]         urem;
    logic [SIZE_W-1:0]         vrem;
    logic                      usat;
    logic                      vsat;
    logic [UV_FRAC_BITS-1:0]   uq;
    logic [UV_FRAC_BITS-1:0]   vq;
    logic [COLOR_W-1:0]        color;
    logic [1:0]                corner;
  } vtx_t;

endpackage

>>> rtl/core/rsqs_ifs.sv
// ----------------------------------------------------------------------------
// Rotated sprite quad setup - channel interfaces
// Sprite request, vertex result and register write channels.
// ----------------------------------------------------------------------------
interface rsqs_sprite_if;
  import rsqs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [TEXEL_BITS-1:0]   src_x;
  logic [TEXEL_BITS-1:0]   src_y;
  logic [TEXEL_BITS-1:0]   src_w;
  logic [TEXEL_BITS-1:0]   src_h;
  logic [SCALE_W-1:0]      scale_factor;
  logic [ANGLE_W-1:0]      angle;
  logic signed [PIVOT_W-1:0] pivot_x;
  logic signed [PIVOT_W-1:0] pivot_y;
  logic [FLIP_W-1:0]       flip_bits;
  logic [COLOR_W-1:0]      color_rgba;

  modport source (output valid, pos_x, pos_y, src_x, src_y, src_w, src_h,
                  scale_factor, angle, pivot_x, pivot_y, flip_bits, color_rgba,
                  input ready);
  modport sink (input valid, pos_x, pos_y, src_x, src_y, src_w, src_h,
                scale_factor, angle, pivot_x, pivot_y, flip_bits, color_rgba,
                output ready);
endinterface

interface rsqs_vertex_if;
  import rsqs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] vert_x;
  logic signed [POS_W-1:0] vert_y;
  logic [UV_W-1:0]         tex_u;
  logic [UV_W-1:0]         tex_v;
  logic [COLOR_W-1:0]      vert_color;
  logic [1:0]              corner;
  logic                    last_corner;

  modport source (output valid, vert_x, vert_y, tex_u, tex_v, vert_color, corner,
                  last_corner, input ready);
  modport sink (input valid, vert_x, vert_y, tex_u, tex_v, vert_color, corner,
                last_corner, output ready);
endinterface

interface rsqs_cfg_if;
  import rsqs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/rotated_sprite_quad_setup.sv
// The first vertex of a sprite leaves after the CORDIC stages, the corner sequencer and the
// vertex pipeline, the other three follow. Throughput: one vertex per cycle unless vtx.ready
// stalls it; the single vertex port and the four-corner sequencer set that figure.
// Reset: clears all valid bits and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// Rotated sprite quad setup
// CORDIC sine/cosine pipeline per sprite, corner sequencer, then a vertex
// pipeline with rotate/scale multipliers and restoring dividers for u and v.
// ----------------------------------------------------------------------------
`include "rotated_sprite_quad_setup_assert.svh"

module rotated_sprite_quad_setup (
  input logic           clk,
  input logic           rst,
  rsqs_cfg_if.sink      cfg,
  rsqs_sprite_if.sink   spr,
  rsqs_vertex_if.source vtx
);
  import rsqs_pkg::*;

  localparam int SP_LAST = CORDIC_STEPS;
  localparam int VX_LAST = VX_DEPTH - 1;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (&v[SUM_W-1:POS_W-1] || ~|v[SUM_W-1:POS_W-1]) begin
      r = v[POS_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  // registers
  logic [SIZE_W-1:0] tex_w;
  logic [SIZE_W-1:0] tex_h;
  logic [OPAC_W-1:0] opacity;
  logic              api_gl;
  logic [SIZE_W-1:0] div_w;
  logic [SIZE_W-1:0] div_h;

  assign cfg.ready = 1'b1;
  assign div_w = (tex_w == '0) ? SIZE_W'(1) : tex_w;
  assign div_h = (tex_h == '0) ? SIZE_W'(1) : tex_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_w   <= SIZE_W'(1);
      tex_h   <= SIZE_W'(1);
      opacity <= OPAC_W'(256);
      api_gl  <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_TEX_W:   tex_w   <= cfg.data[SIZE_W-1:0];
        CFG_TEX_H:   tex_h   <= cfg.data[SIZE_W-1:0];
        CFG_OPACITY: opacity <= cfg.data[OPAC_W-1:0];
        CFG_API:     api_gl  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // sprite entry
  spr_t                  spr_in;
  logic                  fx_in;
  logic                  fy_in;
  logic signed [OX_W-1:0] sw16_s;
  logic signed [OX_W-1:0] sh16_s;
  logic signed [OX_W-1:0] pvx;
  logic signed [OX_W-1:0] pvy;
  logic [OPAC_W+8:0]     aprod;
  logic [7:0]            alpha;

  always_comb begin
    fx_in  = spr.flip_bits[0];
    fy_in  = spr.flip_bits[1] | (spr.flip_bits[2] & api_gl);
    sw16_s = $signed(OX_W'({spr.src_w, 4'b0000}));
    sh16_s = $signed(OX_W'({spr.src_h, 4'b0000}));
    pvx    = OX_W'(spr.pivot_x);
    pvy    = OX_W'(spr.pivot_y);
    aprod  = (OPAC_W+9)'(spr.color_rgba[31:24]) * (OPAC_W+9)'(opacity)
             + (OPAC_W+9)'(128);
    alpha  = (|aprod[OPAC_W+8:16]) ? 8'hFF : aprod[15:8];
    spr_in.px    = spr.pos_x;
    spr_in.py    = spr.pos_y;
    spr_in.sx    = spr.src_x;
    spr_in.sy    = spr.src_y;
    spr_in.sw    = spr.src_w;
    spr_in.sh    = spr.src_h;
    spr_in.fx    = fx_in;
    spr_in.fy    = fy_in;
    spr_in.ox    = fx_in ? (sw16_s - pvx) : pvx;
    spr_in.oy    = fy_in ? (sh16_s - pvy) : pvy;
    spr_in.scl   = spr.scale_factor;
    spr_in.color = {alpha, spr.color_rgba[23:0]};
    spr_in.quad  = spr.angle[15:14];
    spr_in.x     = CORDIC_K;
    spr_in.y     = '0;
    spr_in.z     = $signed(Z_W'({spr.angle[13:0], 8'h00}));
  end

  // CORDIC pipeline, one rotation step per stage
  spr_t sp       [0:SP_LAST];
  logic sp_valid [0:SP_LAST];
  spr_t sp_next  [1:SP_LAST];
  logic sp_adv;
  logic ex_free;

  always_comb begin
    for (int i = 1; i <= SP_LAST; i++) begin
      sp_next[i] = sp[i-1];
      if (!sp[i-1].z[Z_W-1]) begin
        sp_next[i].x = sp[i-1].x - (sp[i-1].y >>> (i-1));
        sp_next[i].y = sp[i-1].y + (sp[i-1].x >>> (i-1));
        sp_next[i].z = sp[i-1].z - $signed(ATAN_TURNS[i-1]);
      end else begin
        sp_next[i].x = sp[i-1].x + (sp[i-1].y >>> (i-1));
        sp_next[i].y = sp[i-1].y - (sp[i-1].x >>> (i-1));
        sp_next[i].z = sp[i-1].z + $signed(ATAN_TURNS[i-1]);
      end
    end
  end

  assign sp_adv    = !sp_valid[SP_LAST] || ex_free;
  assign spr.ready = sp_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= SP_LAST; i++) sp_valid[i] <= 1'b0;
    end else if (sp_adv) begin
      sp_valid[0] <= spr.valid;
      for (int i = 1; i <= SP_LAST; i++) sp_valid[i] <= sp_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (sp_adv) begin
      sp[0] <= spr_in;
      for (int i = 1; i <= SP_LAST; i++) sp[i] <= sp_next[i];
    end
  end

  // corner sequencer: x holds cos, y holds sin after the quadrant fold
  spr_t       ex;
  spr_t       ex_in;
  logic       ex_valid;
  logic [1:0] ex_k;
  logic       vx_en;
  logic       ex_emit;

  always_comb begin
    ex_in = sp[SP_LAST];
    case (sp[SP_LAST].quad)
      2'd0: begin
        ex_in.x = sp[SP_LAST].x;
        ex_in.y = sp[SP_LAST].y;
      end
      2'd1: begin
        ex_in.x = -sp[SP_LAST].y;
        ex_in.y = sp[SP_LAST].x;
      end
      2'd2: begin
        ex_in.x = -sp[SP_LAST].x;
        ex_in.y = -sp[SP_LAST].y;
      end
      default: begin
        ex_in.x = sp[SP_LAST].y;
        ex_in.y = -sp[SP_LAST].x;
      end
    endcase
  end

  assign ex_emit = ex_valid && vx_en;
  assign ex_free = !ex_valid || (vx_en && ex_k == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
      ex_k     <= 2'd0;
    end else begin
      if (ex_emit) ex_k <= ex_k + 2'd1;
      if (ex_free) ex_valid <= sp_valid[SP_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (ex_free && sp_valid[SP_LAST]) ex <= ex_in;
  end

  // vertex entry
  vtx_t                    vx_in;
  logic signed [OFF_W-1:0] sw16_o;
  logic signed [OFF_W-1:0] sh16_o;
  logic [TEX_W-1:0]        tu;
  logic [TEX_W-1:0]        tv;

  always_comb begin
    sw16_o = $signed(OFF_W'({ex.sw, 4'b0000}));
    sh16_o = $signed(OFF_W'({ex.sh, 4'b0000}));
    tu = TEX_W'(ex.sx) + (((ex_k[1] ^ ex.fx)) ? TEX_W'(ex.sw) : '0);
    tv = TEX_W'(ex.sy) + (((ex_k[0] ^ ex.fy)) ? TEX_W'(ex.sh) : '0);
    vx_in        = '0;
    vx_in.px     = ex.px;
    vx_in.py     = ex.py;
    vx_in.scl    = ex.scl;
    vx_in.offx   = (ex_k[1] ? sw16_o : '0) - OFF_W'(ex.ox);
    vx_in.offy   = OFF_W'(ex.oy) - (ex_k[0] ? sh16_o : '0);
    vx_in.c      = ex.x;
    vx_in.s      = ex.y;
    vx_in.ud     = div_w;
    vx_in.vd     = div_h;
    vx_in.usat   = (tu >= TEX_W'(div_w));
    vx_in.vsat   = (tv >= TEX_W'(div_h));
    vx_in.urem   = SIZE_W'(tu);
    vx_in.vrem   = SIZE_W'(tv);
    vx_in.color  = ex.color;
    vx_in.corner = ex_k;
  end

  // vertex pipeline: rotate, scale, round in the first four stages;
  // one quotient bit of u and v in every stage
  vtx_t vx       [0:VX_LAST];
  logic vx_valid [0:VX_LAST];
  vtx_t vx_next  [1:VX_LAST];

  always_comb begin
    logic signed [SPROD_W-1:0] rnd_x;
    logic signed [SPROD_W-1:0] rnd_y;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic [SIZE_W:0]           ru;
    logic [SIZE_W:0]           rv;
    rnd_x = '0;
    rnd_y = '0;
    sum_x = '0;
    sum_y = '0;
    ru    = '0;
    rv    = '0;
    for (int i = 1; i <= VX_LAST; i++) begin
      vx_next[i] = vx[i-1];
      if (i == 1) begin
        vx_next[i].mx1 = PROD_W'(vx[i-1].offx * vx[i-1].c);
        vx_next[i].mx2 = PROD_W'(vx[i-1].offy * vx[i-1].s);
        vx_next[i].my1 = PROD_W'(vx[i-1].offx * vx[i-1].s);
        vx_next[i].my2 = PROD_W'(vx[i-1].offy * vx[i-1].c);
      end
      if (i == 2) begin
        vx_next[i].rx = ROT_W'(vx[i-1].mx1) - ROT_W'(vx[i-1].mx2);
        vx_next[i].ry = ROT_W'(vx[i-1].my1) + ROT_W'(vx[i-1].my2);
      end
      if (i == 3) begin
        vx_next[i].prx = SPROD_W'(vx[i-1].rx * $signed({1'b0, vx[i-1].scl}));
        vx_next[i].pry = SPROD_W'(vx[i-1].ry * $signed({1'b0, vx[i-1].scl}));
      end
      if (i == 4) begin
        rnd_x = vx[i-1].prx + SPROD_W'(2 ** (RND_SHIFT - 1));
        rnd_y = vx[i-1].pry + SPROD_W'(2 ** (RND_SHIFT - 1));
        sum_x = SUM_W'(rnd_x >>> RND_SHIFT) + SUM_W'(vx[i-1].px);
        sum_y = SUM_W'(rnd_y >>> RND_SHIFT) + SUM_W'(vx[i-1].py);
        vx_next[i].vx = sat_pos(sum_x);
        vx_next[i].vy = sat_pos(sum_y);
      end
      ru = {vx[i-1].urem, 1'b0};
      if (ru >= {1'b0, vx[i-1].ud}) begin
        vx_next[i].urem = SIZE_W'(ru - {1'b0, vx[i-1].ud});
        vx_next[i].uq   = {vx[i-1].uq[UV_FRAC_BITS-2:0], 1'b1};
      end else begin
        vx_next[i].urem = ru[SIZE_W-1:0];
        vx_next[i].uq   = {vx[i-1].uq[UV_FRAC_BITS-2:0], 1'b0};
      end
      rv = {vx[i-1].vrem, 1'b0};
      if (rv >= {1'b0, vx[i-1].vd}) begin
        vx_next[i].vrem = SIZE_W'(rv - {1'b0, vx[i-1].vd});
        vx_next[i].vq   = {vx[i-1].vq[UV_FRAC_BITS-2:0], 1'b1};
      end else begin
        vx_next[i].vrem = rv[SIZE_W-1:0];
        vx_next[i].vq   = {vx[i-1].vq[UV_FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  assign vx_en = !vx_valid[VX_LAST] || vtx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= VX_LAST; i++) vx_valid[i] <= 1'b0;
    end else if (vx_en) begin
      vx_valid[0] <= ex_valid;
      for (int i = 1; i <= VX_LAST; i++) vx_valid[i] <= vx_valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (vx_en) begin
      vx[0] <= vx_in;
      for (int i = 1; i <= VX_LAST; i++) vx[i] <= vx_next[i];
    end
  end

  // result beat
  assign vtx.valid       = vx_valid[VX_LAST];
  assign vtx.vert_x      = vx[VX_LAST].vx;
  assign vtx.vert_y      = vx[VX_LAST].vy;
  assign vtx.tex_u       = vx[VX_LAST].usat ? UV_W'(2 ** UV_FRAC_BITS)
                                             : {1'b0, vx[VX_LAST].uq};
  assign vtx.tex_v       = vx[VX_LAST].vsat ? UV_W'(2 ** UV_FRAC_BITS)
                                             : {1'b0, vx[VX_LAST].vq};
  assign vtx.vert_color  = vx[VX_LAST].color;
  assign vtx.corner      = vx[VX_LAST].corner;
  assign vtx.last_corner = (vx[VX_LAST].corner == 2'd3);

  `RSQS_ASSERT_NXT(a_ex_hold, clk, rst, ex_valid && !vx_en, ex_valid && ex_k == $past(ex_k))
  `RSQS_ASSERT_NXT(a_ex_drain, clk, rst, ex_valid && vx_en && ex_k == 2'd3 && !sp_valid[SP_LAST], !ex_valid)
  `RSQS_ASSERT_NXT(a_sp_hold, clk, rst, sp_valid[SP_LAST] && !sp_adv, sp_valid[SP_LAST])
  `RSQS_ASSERT_IMP(a_uv_sat, clk, rst, vtx.valid && vtx.tex_u[UV_FRAC_BITS], vtx.tex_u[UV_FRAC_BITS-1:0] == '0)

endmodule
